### rtl/pnm_pkg.sv
`default_nettype none

package pnm_pkg;

	localparam int unsigned LINE_LIMIT_DEF = 70;
	localparam int unsigned CMD_BYTES = 6;
	localparam int unsigned CMD_IDX_W = $clog2(CMD_BYTES);
	localparam int unsigned CMDQ_DEPTH = 2;
	localparam int unsigned CMDQ_AW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

	localparam logic [1:0] REG_FORMAT_MODE   = 2'd0;
	localparam logic [1:0] REG_MAX_SAMPLE    = 2'd1;
	localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

	typedef enum logic [1:0] {
		FMT_RAW_BIT,
		FMT_PLAIN_BIT,
		FMT_RAW_SAMPLE,
		FMT_PLAIN_SAMPLE
	} fmt_t;

	typedef struct packed {
		logic [15:0] sample_value;
		logic        row_end;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       clamped;
		logic       bit_error;
	} result_t;

	typedef struct packed {
		logic [CMD_BYTES-1:0][7:0] bytes;
		logic [CMD_IDX_W-1:0]      last_idx;
		logic                      clamped;
		logic                      bit_error;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/pnm_front.sv
`default_nettype none

module pnm_front #(
	parameter int unsigned LINE_LIMIT = pnm_pkg::LINE_LIMIT_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pnm_pkg::fmt_t  format_mode,
	input  wire logic [15:0]    max_sample,
	input  wire logic [1:0]     channel_count,
	input  wire logic           push,
	output logic                full,
	input  wire pnm_pkg::item_t item,
	output logic                cmd_push,
	output pnm_pkg::cmd_t       cmd,
	input  wire logic           q_full
);
	import pnm_pkg::*;

	localparam logic [7:0] LL_B  = 8'(LINE_LIMIT);
	localparam logic [7:0] LL_M1 = 8'(LINE_LIMIT - 1);
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [3:0] CH_DIGIT_HI = 4'h3;

	typedef enum logic [1:0] {
		F_IDLE,
		F_CONV,
		F_BUILD
	} fstate_t;

	fstate_t         state_q, state_d;
	logic [7:0]      acc_q, acc_d;
	logic [2:0]      pos_q, pos_d;
	logic            perr_q, perr_d;
	logic [6:0]      lc_q, lc_d;
	logic [1:0]      phase_q, phase_d;
	logic [15:0]     x_q, x_d;
	logic [2:0]      nd_q, nd_d;
	logic [3:0]      digs_q [5];
	logic [3:0]      digs_d [5];
	logic [2:0]      width_q, width_d;
	logic [7:0]      sep_q, sep_d;
	logic            clamp_q, clamp_d;

	logic            accept;
	logic [1:0]      chns;
	logic [2:0]      phase_inc;
	logic [15:0]     vc;
	logic            clamp_w;
	logic [2:0]      width_w;
	logic [4:0]      six_ch;
	logic [6:0]      lc_w;
	logic            nl_w;
	logic [7:0]      acc_n;
	logic            perr_n;
	logic [6:0]      lc_mid;
	logic [31:0]     prod;
	logic [15:0]     quot;
	logic [3:0]      dig;
	cmd_t            build;

	function automatic logic [6:0] sat_add(input logic [6:0] c, input logic [2:0] k);
		logic [7:0] s;
		s = {1'b0, c} + {5'b0, k};
		return s[7] ? 7'd127 : s[6:0];
	endfunction

	assign full   = (state_q != F_IDLE) || q_full;
	assign accept = push && !full;

	assign chns      = (channel_count == 2'd0) ? 2'd1 : channel_count;
	assign phase_inc = {1'b0, phase_q} + 3'd1;
	assign clamp_w   = item.sample_value > max_sample;
	assign vc        = clamp_w ? max_sample : item.sample_value;
	assign width_w   = (max_sample > 16'd9999) ? 3'd5 :
	                   (max_sample > 16'd999)  ? 3'd4 :
	                   (max_sample > 16'd99)   ? 3'd3 :
	                   (max_sample > 16'd9)    ? 3'd2 : 3'd1;
	assign six_ch    = {1'b0, chns, 2'b00} + {2'b00, chns, 1'b0};
	assign lc_w      = sat_add(lc_q, width_w);
	assign nl_w      = ((({1'b0, lc_w} + {3'b000, six_ch}) > LL_B) && (phase_q == 2'd0))
	                   || item.row_end;
	assign acc_n     = acc_q | ((item.sample_value == 16'd0) ? (8'h80 >> pos_q) : 8'h00);
	assign perr_n    = perr_q | (item.sample_value > 16'd1);
	assign lc_mid    = ({1'b0, lc_q} > LL_M1) ? 7'd0 : sat_add(lc_q, 3'd1);

	assign prod = x_q * 16'd52429;
	assign quot = {3'b000, prod[31:19]};
	assign dig  = 4'(x_q - ({quot[12:0], 3'b000} + {quot[14:0], 1'b0}));

	always_comb begin
		logic [2:0] pad;
		logic [2:0] jj;
		logic [2:0] di;
		pad   = width_q - nd_q;
		build = '0;
		build.last_idx = CMD_IDX_W'(width_q);
		build.clamped  = clamp_q;
		for (int j = 0; j < CMD_BYTES; j++) begin
			jj = 3'(j);
			di = width_q - 3'd1 - jj;
			if (jj < pad) begin
				build.bytes[j] = CH_SPACE;
			end else if (jj < width_q) begin
				build.bytes[j] = {CH_DIGIT_HI, digs_q[di]};
			end else if (jj == width_q) begin
				build.bytes[j] = sep_q;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		acc_d   = acc_q;
		pos_d   = pos_q;
		perr_d  = perr_q;
		lc_d    = lc_q;
		phase_d = phase_q;
		x_d     = x_q;
		nd_d    = nd_q;
		digs_d  = digs_q;
		width_d = width_q;
		sep_d   = sep_q;
		clamp_d = clamp_q;
		cmd_push = 1'b0;
		cmd      = '0;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					case (format_mode)
						FMT_RAW_BIT: begin
							if (pos_q == 3'd7 || item.row_end) begin
								cmd_push      = 1'b1;
								cmd.bytes[0]  = acc_n;
								cmd.bit_error = perr_n;
								acc_d  = '0;
								pos_d  = '0;
								perr_d = 1'b0;
							end else begin
								acc_d  = acc_n;
								pos_d  = pos_q + 3'd1;
								perr_d = perr_n;
							end
						end
						FMT_PLAIN_BIT: begin
							cmd_push      = 1'b1;
							cmd.bit_error = item.sample_value > 16'd1;
							cmd.bytes[0]  = ({1'b0, lc_q} > LL_M1) ? CH_NL : CH_SPACE;
							cmd.bytes[1]  = {CH_DIGIT_HI, 3'b000, ~item.sample_value[0]};
							cmd.bytes[2]  = CH_NL;
							cmd.last_idx  = item.row_end ? CMD_IDX_W'(2) : CMD_IDX_W'(1);
							lc_d = sat_add(lc_mid, 3'd1);
						end
						FMT_RAW_SAMPLE: begin
							cmd_push    = 1'b1;
							cmd.clamped = clamp_w;
							if (max_sample > 16'd255) begin
								cmd.bytes[0] = vc[15:8];
								cmd.bytes[1] = vc[7:0];
								cmd.last_idx = CMD_IDX_W'(1);
							end else begin
								cmd.bytes[0] = vc[7:0];
							end
						end
						FMT_PLAIN_SAMPLE: begin
							x_d     = vc;
							nd_d    = '0;
							width_d = width_w;
							sep_d   = nl_w ? CH_NL : CH_SPACE;
							clamp_d = clamp_w;
							lc_d    = nl_w ? 7'd0 : sat_add(lc_w, 3'd1);
							state_d = F_CONV;
						end
						default: begin
						end
					endcase
					if (item.row_end) begin
						lc_d    = '0;
						phase_d = '0;
						acc_d   = '0;
						pos_d   = '0;
						perr_d  = 1'b0;
					end else begin
						phase_d = (phase_inc >= {1'b0, chns}) ? 2'd0 : phase_inc[1:0];
					end
				end
			end
			F_CONV: begin
				digs_d[nd_q] = dig;
				nd_d = nd_q + 3'd1;
				x_d  = quot;
				if (quot == 16'd0 || nd_q == 3'd4) begin
					state_d = F_BUILD;
				end
			end
			F_BUILD: begin
				cmd = build;
				if (!q_full) begin
					cmd_push = 1'b1;
					state_d  = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			acc_q   <= '0;
			pos_q   <= '0;
			perr_q  <= 1'b0;
			lc_q    <= '0;
			phase_q <= '0;
			nd_q    <= '0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
			pos_q   <= pos_d;
			perr_q  <= perr_d;
			lc_q    <= lc_d;
			phase_q <= phase_d;
			nd_q    <= nd_d;
		end
	end

	always_ff @(posedge clk) begin
		x_q     <= x_d;
		digs_q  <= digs_d;
		width_q <= width_d;
		sep_q   <= sep_d;
		clamp_q <= clamp_d;
	end

`ifndef SYNTH
	a_conv_digits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_CONV |-> nd_q < 3'd5)
		else $error("digit count ran past five");

	a_build_fits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == F_BUILD |-> nd_q <= width_q)
		else $error("decimal digits exceed field width");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !q_full)
		else $error("request pushed into full queue");
`endif

endmodule

`default_nettype wire

### rtl/pnm_cmdq.sv
`default_nettype none

module pnm_cmdq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire pnm_pkg::cmd_t wr_cmd,
	output logic               full,
	input  wire logic          rd_en,
	output pnm_pkg::cmd_t      rd_cmd,
	output logic               empty
);
	import pnm_pkg::*;

	localparam logic [CMDQ_AW-1:0] LAST_PTR = CMDQ_AW'(CMDQ_DEPTH - 1);
	localparam logic [CMDQ_AW:0]   DEPTH_C  = (CMDQ_AW + 1)'(CMDQ_DEPTH);

	cmd_t               ent_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wr_ptr_q;
	logic [CMDQ_AW-1:0] rd_ptr_q;
	logic [CMDQ_AW:0]   count_q;

	assign full   = count_q == DEPTH_C;
	assign empty  = count_q == '0;
	assign rd_cmd = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_ptr_q] <= wr_cmd;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("queue count exceeds depth");
`endif

endmodule

`default_nettype wire

### rtl/pnm_back.sv
`default_nettype none

module pnm_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pnm_pkg::cmd_t q_cmd,
	input  wire logic          q_empty,
	output logic               q_pop,
	output logic               empty,
	input  wire logic          pop,
	output pnm_pkg::result_t   result
);
	import pnm_pkg::*;

	cmd_t                 cur_q;
	logic                 valid_q;
	logic [CMD_IDX_W-1:0] idx_q;

	logic take;
	logic finish;

	assign empty  = !valid_q;
	assign result.out_byte  = cur_q.bytes[idx_q];
	assign result.run_last  = idx_q == cur_q.last_idx;
	assign result.clamped   = cur_q.clamped;
	assign result.bit_error = cur_q.bit_error;

	assign take   = pop && valid_q;
	assign finish = take && result.run_last;
	assign q_pop  = (!valid_q || finish) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
				idx_q   <= '0;
			end else if (finish) begin
				valid_q <= 1'b0;
				idx_q   <= '0;
			end else if (take) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_cmd;
		end
	end

`ifndef SYNTH
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> idx_q <= cur_q.last_idx)
		else $error("byte index past last byte of request");
`endif

endmodule

`default_nettype wire

### rtl/pnm_row_byte_encoder_unit.sv
// Path: a raw or bitmap request goes through the request queue and the back end's register
// before its first byte can be popped; plain decimal first runs the divide-by-ten loop over the
// sample's d digits (1 to 5). Output: one byte per cycle while pop is held and a request waits;
// plain decimal input is held off by full in the one-digit-per-cycle loop and the build state,
// and once the request queue fills the output byte rate bounds the input in every mode.
// Reset (arst_n low, asynchronous) clears row state and the queue and loads the
// registers with mode raw samples, max sample 255, one channel.
`default_nettype none

module pnm_row_byte_encoder_unit #(
	parameter int unsigned LINE_LIMIT = pnm_pkg::LINE_LIMIT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_addr,
	input  wire logic [15:0]      cfg_data,
	input  wire logic             push,
	output logic                  full,
	input  wire pnm_pkg::item_t   item,
	output logic                  empty,
	input  wire logic             pop,
	output pnm_pkg::result_t      result
);
	import pnm_pkg::*;

	fmt_t        fmt_q;
	logic [15:0] max_q;
	logic [1:0]  chn_q;

	logic cmd_push;
	cmd_t cmd;
	logic q_full;
	cmd_t q_cmd;
	logic q_empty;
	logic q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RAW_SAMPLE;
			max_q <= 16'd255;
			chn_q <= 2'd1;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_FORMAT_MODE:   fmt_q <= fmt_t'(cfg_data[1:0]);
				REG_MAX_SAMPLE:    max_q <= cfg_data;
				REG_CHANNEL_COUNT: chn_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	pnm_front #(
		.LINE_LIMIT(LINE_LIMIT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.format_mode   (fmt_q),
		.max_sample    (max_q),
		.channel_count (chn_q),
		.push          (push),
		.full          (full),
		.item          (item),
		.cmd_push      (cmd_push),
		.cmd           (cmd),
		.q_full        (q_full)
	);

	pnm_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_cmd (q_cmd),
		.empty  (q_empty)
	);

	pnm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_cmd   (q_cmd),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

`default_nettype wire

### dv/pnm_row_byte_encoder_unit_tb.sv
`timescale 1ns / 100ps

module pnm_row_byte_encoder_unit_tb;
	import pnm_pkg::*;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	localparam int LINE_MAX = LINE_LIMIT_DEF;
	localparam int SETTLE_CYCLES = 12;
	localparam int PLAN_ROWS = 25;

	typedef struct packed {
		fmt_t        fmt;
		logic [15:0] maxv;
		logic [1:0]  chans;
		item_t       req;
		logic        known;
		result_t     want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [15:0] cfg_data = '0;
	logic        push = 1'b0;
	logic        full;
	item_t       item = '0;
	logic        empty;
	logic        pop = 1'b0;
	result_t     result;

	fmt_t        cur_fmt = FMT_RAW_SAMPLE;
	logic [15:0] cur_max = 16'd255;
	logic [1:0]  cur_chans = 2'd1;

	logic [7:0]  bit_acc = '0;
	logic [2:0]  bit_pos = '0;
	logic [6:0]  line_cnt = '0;
	logic [1:0]  chan_phase = '0;
	bit          bit_err_hold = 1'b0;

	result_t     fresh_bytes[$];
	result_t     pending_bytes[$];
	int          mismatch_count = 0;
	bit          steady = 1'b0;
	plan_row_t   plan[PLAN_ROWS];

	pnm_row_byte_encoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [6:0] line_add(logic [6:0] c, int k);
		int s;
		s = int'(c) + k;
		return (s > 127) ? 7'd127 : 7'(s);
	endfunction

	function automatic void encode_sample(item_t req);
		logic [15:0] v;
		logic [7:0]  out_q[$];
		logic [7:0]  digs[5];
		bit          clamp;
		bit          berr;
		int          chns;
		int          nd;
		int          width;
		int unsigned x;
		int unsigned m;
		result_t     r;
		v = req.sample_value;
		clamp = 1'b0;
		berr = 1'b0;
		chns = (cur_chans == 2'd0) ? 1 : int'(cur_chans);
		fresh_bytes.delete();
		case (cur_fmt)
			FMT_RAW_BIT: begin
				if (v > 16'd1)
					bit_err_hold = 1'b1;
				if (v == 16'd0)
					bit_acc = bit_acc | (8'h80 >> bit_pos);
				if (bit_pos == 3'd7 || req.row_end) begin
					out_q.push_back(bit_acc);
					berr = bit_err_hold;
					bit_acc = '0;
					bit_pos = '0;
					bit_err_hold = 1'b0;
				end else begin
					bit_pos = bit_pos + 3'd1;
				end
			end
			FMT_PLAIN_BIT: begin
				berr = v > 16'd1;
				if (int'(line_cnt) > LINE_MAX - 1) begin
					out_q.push_back(CH_NL);
					line_cnt = '0;
				end else begin
					out_q.push_back(CH_SPACE);
					line_cnt = line_add(line_cnt, 1);
				end
				out_q.push_back(CH_ZERO + {7'd0, ~v[0]});
				line_cnt = line_add(line_cnt, 1);
				if (req.row_end)
					out_q.push_back(CH_NL);
			end
			FMT_RAW_SAMPLE: begin
				if (v > cur_max) begin
					v = cur_max;
					clamp = 1'b1;
				end
				if (cur_max > 16'd255)
					out_q.push_back(v[15:8]);
				out_q.push_back(v[7:0]);
			end
			default: begin
				if (v > cur_max) begin
					v = cur_max;
					clamp = 1'b1;
				end
				x = v;
				nd = 0;
				do begin
					digs[nd] = CH_ZERO + 8'(x % 10);
					nd++;
					x = x / 10;
				end while (x > 0 && nd < 5);
				m = cur_max;
				width = 0;
				do begin
					width++;
					m = m / 10;
				end while (m > 0);
				if (width < nd)
					width = nd;
				for (int k = nd; k < width; k++)
					out_q.push_back(CH_SPACE);
				for (int k = nd; k > 0; k--)
					out_q.push_back(digs[k - 1]);
				line_cnt = line_add(line_cnt, width);
				if ((int'(line_cnt) > LINE_MAX - 6 * chns && chan_phase == 2'd0)
						|| req.row_end) begin
					out_q.push_back(CH_NL);
					line_cnt = '0;
				end else begin
					out_q.push_back(CH_SPACE);
					line_cnt = line_add(line_cnt, 1);
				end
			end
		endcase
		if (req.row_end) begin
			line_cnt = '0;
			chan_phase = '0;
			bit_acc = '0;
			bit_pos = '0;
			bit_err_hold = 1'b0;
		end else begin
			chan_phase = (int'(chan_phase) + 1 >= chns) ? 2'd0 : chan_phase + 2'd1;
		end
		foreach (out_q[i]) begin
			r.out_byte = out_q[i];
			r.run_last = (i == out_q.size() - 1);
			r.clamped = clamp;
			r.bit_error = berr;
			fresh_bytes.push_back(r);
		end
	endfunction

	task automatic wait_drained();
		push <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(fmt_t f, logic [15:0] mx, logic [1:0] ch);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_addr <= REG_FORMAT_MODE;
		cfg_data <= 16'(f);
		@(posedge clk);
		cfg_addr <= REG_MAX_SAMPLE;
		cfg_data <= mx;
		@(posedge clk);
		cfg_addr <= REG_CHANNEL_COUNT;
		cfg_data <= 16'(ch);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_fmt = f;
		cur_max = mx;
		cur_chans = ch;
	endtask

	task automatic offer(item_t req, bit known, result_t want);
		while (!steady && $urandom_range(99) < 9) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= req;
		@(posedge clk);
		while (full)
			@(posedge clk);
		encode_sample(req);
		if (known)
			pending_bytes.push_back(want);
		else
			foreach (fresh_bytes[k])
				pending_bytes.push_back(fresh_bytes[k]);
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (pop && !empty) begin
			if (pending_bytes.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected byte %h", $time, result.out_byte);
			end else begin
				want = pending_bytes.pop_front();
				if (result.out_byte !== want.out_byte) begin
					mismatch_count++;
					$display("%0t: out_byte expected %h got %h", $time,
						want.out_byte, result.out_byte);
				end
				if (result.run_last !== want.run_last) begin
					mismatch_count++;
					$display("%0t: run_last expected %b got %b", $time,
						want.run_last, result.run_last);
				end
				if (result.clamped !== want.clamped) begin
					mismatch_count++;
					$display("%0t: clamped expected %b got %b", $time,
						want.clamped, result.clamped);
				end
				if (result.bit_error !== want.bit_error) begin
					mismatch_count++;
					$display("%0t: bit_error expected %b got %b", $time,
						want.bit_error, result.bit_error);
				end
			end
		end
		pop <= steady || ($urandom_range(99) >= 9);
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		item_t       req;
		fmt_t        f;
		logic [15:0] mx;
		int          col;
		int          row_len;
		col = 0;
		row_len = 1;

		plan[0]  = '{FMT_RAW_SAMPLE, 16'd255, 2'd1, '{16'd0, 1'b0}, 1'b1,
			'{8'h00, 1'b1, 1'b0, 1'b0}};
		plan[1]  = '{FMT_RAW_SAMPLE, 16'd255, 2'd1, '{16'd255, 1'b0}, 1'b1,
			'{8'hFF, 1'b1, 1'b0, 1'b0}};
		plan[2]  = '{FMT_RAW_SAMPLE, 16'd255, 2'd1, '{16'hFFFF, 1'b0}, 1'b1,
			'{8'hFF, 1'b1, 1'b1, 1'b0}};
		plan[3]  = '{FMT_RAW_SAMPLE, 16'd255, 2'd1, '{16'd200, 1'b1}, 1'b1,
			'{8'hC8, 1'b1, 1'b0, 1'b0}};
		plan[4]  = '{FMT_RAW_SAMPLE, 16'hFFFF, 2'd1, '{16'hABCD, 1'b1}, 1'b0, '0};
		plan[5]  = '{FMT_RAW_SAMPLE, 16'hFFFF, 2'd1, '{16'hFFFF, 1'b0}, 1'b0, '0};
		plan[6]  = '{FMT_RAW_SAMPLE, 16'd0, 2'd1, '{16'd5, 1'b1}, 1'b1,
			'{8'h00, 1'b1, 1'b1, 1'b0}};
		plan[7]  = '{FMT_RAW_BIT, 16'd255, 2'd1, '{16'd0, 1'b1}, 1'b1,
			'{8'h80, 1'b1, 1'b0, 1'b0}};
		plan[8]  = '{FMT_RAW_BIT, 16'd255, 2'd1, '{16'd7, 1'b1}, 1'b1,
			'{8'h00, 1'b1, 1'b0, 1'b1}};
		for (int i = 0; i < 7; i++)
			plan[9 + i] = '{FMT_RAW_BIT, 16'd255, 2'd1, '{16'(~i & 1), 1'b0}, 1'b0, '0};
		plan[16] = '{FMT_RAW_BIT, 16'd255, 2'd1, '{16'd0, 1'b1}, 1'b1,
			'{8'h55, 1'b1, 1'b0, 1'b0}};
		plan[17] = '{FMT_PLAIN_BIT, 16'd255, 2'd1, '{16'd0, 1'b0}, 1'b0, '0};
		plan[18] = '{FMT_PLAIN_BIT, 16'd255, 2'd1, '{16'd2, 1'b1}, 1'b0, '0};
		plan[19] = '{FMT_PLAIN_SAMPLE, 16'hFFFF, 2'd3, '{16'd0, 1'b0}, 1'b0, '0};
		plan[20] = '{FMT_PLAIN_SAMPLE, 16'hFFFF, 2'd3, '{16'hFFFF, 1'b0}, 1'b0, '0};
		plan[21] = '{FMT_PLAIN_SAMPLE, 16'hFFFF, 2'd3, '{16'd12345, 1'b1}, 1'b0, '0};
		plan[22] = '{FMT_PLAIN_SAMPLE, 16'd0, 2'd0, '{16'd9, 1'b1}, 1'b0, '0};
		plan[23] = '{FMT_PLAIN_SAMPLE, 16'd9, 2'd2, '{16'd10, 1'b0}, 1'b0, '0};
		plan[24] = '{FMT_PLAIN_SAMPLE, 16'd9, 2'd2, '{16'd0, 1'b1}, 1'b0, '0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (plan[i].fmt != cur_fmt || plan[i].maxv != cur_max
					|| plan[i].chans != cur_chans)
				program_regs(plan[i].fmt, plan[i].maxv, plan[i].chans);
			offer(plan[i].req, plan[i].known, plan[i].want);
		end

		for (int p = 0; p < 9; p++) begin
			steady = (p == 4 || p == 5);
			f = (p < 8) ? fmt_t'(p % 4) : fmt_t'($urandom_range(3));
			case ($urandom_range(5))
				0: mx = 16'd1;
				1: mx = 16'hFFFF;
				2: mx = 16'd255;
				3: mx = 16'd256;
				4: mx = 16'($urandom_range(999, 2));
				default: mx = 16'($urandom);
			endcase
			program_regs(f, mx, 2'($urandom_range(3)));
			for (int n = 0; n < 30; n++) begin
				// hold off until the encoder has drained
				if (p == 2 && n == 15)
					wait_drained();
				if (col == 0)
					row_len = ($urandom_range(3) == 0) ? 8 * $urandom_range(3, 1)
						: $urandom_range(60, 1);
				if (cur_fmt == FMT_RAW_BIT || cur_fmt == FMT_PLAIN_BIT) begin
					req.sample_value = ($urandom_range(99) < 90) ? 16'($urandom_range(1))
						: 16'($urandom);
				end else begin
					case ($urandom_range(4))
						0: req.sample_value = 16'($urandom);
						1: req.sample_value = cur_max;
						2: req.sample_value = cur_max + 16'd1;
						3: req.sample_value = 16'd0;
						default: req.sample_value = 16'($urandom_range(cur_max));
					endcase
				end
				req.row_end = (col == row_len - 1);
				col = req.row_end ? 0 : col + 1;
				offer(req, 1'b0, '0);
			end
		end
		steady = 1'b0;

		wait_drained();
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
